FILE: design/bhs_pkg.sv
`timescale 1ns / 1ps
package bhs_pkg;
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CHECK = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLRH,
        S_DECIDE,
        S_UNDO_RD,
        S_UNDO_WAIT,
        S_UNDO_WR,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_WALK_RD,
        S_WALK_WAIT,
        S_WALK_CMP,
        S_PUT_WR,
        S_OUT
    } state_t;
endpackage

FILE: design/backtrackable_hash_set_unit.sv
`timescale 1ns / 1ps
// Backtrackable hash set with an undo trail.
// s_axis carries one request: func (put/check/clear/none), a mark (trail length to
// keep) and a key. Put and check first pop trail entries above the mark,
// unlinking each from its bucket chain, then put appends the key or check
// walks the key's bucket chain. Clear pops everything.
// m_axis returns one result per request: mark_out, found, status.
// Each popped entry passes S_UNDO_RD, S_UNDO_WAIT and S_UNDO_WR; a check then
// reads the bucket head and walks the chain (S_WALK_RD, S_WALK_WAIT, S_WALK_CMP
// per entry), a put reads the head and writes in S_PUT_WR. Every step goes through
// the bucket-head and trail RAM ports, one access per cycle; s_axis_tready is low while a request runs.
// After reset a clearing pass writes every bucket head, with s_axis_tready
// low. The result is held on m_axis_tdata until m_axis_tready; the
// next request is taken the cycle after it leaves.
module backtrackable_hash_set_unit
    import bhs_pkg::*;
#(
    parameter int BUCKETS  = 1024,
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // func[1:0], mark[12:2], key[44:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // mark_out[10:0], found[11], status[13:12]
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] keep_reg, keep_next;
    logic [1:0] func_reg, func_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [LW-1:0] link_reg, link_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [10:0] mo_reg, mo_next;
    logic found_reg, found_next;
    logic [1:0] st_reg, st_next;

    logic hwe; logic [BW-1:0] hwa, hra; logic [LW-1:0] hwd, hrd;
    logic twe; logic [CW-1:0] twa, tra;
    logic [KEY_BITS+LW-1:0] twd, trd;
    logic [KEY_BITS-1:0] trd_key;
    logic [LW-1:0] trd_next;

    bhs_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
        .clk(clk), .we(hwe), .waddr(hwa), .wdata(hwd), .raddr(hra), .rdata(hrd));
    bhs_ram #(.WIDTH(KEY_BITS + LW), .DEPTH(CAPACITY)) u_trail (
        .clk(clk), .we(twe), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd));

    assign trd_key  = trd[KEY_BITS+LW-1:LW];
    assign trd_next = trd[LW-1:0];

    function automatic logic [BW-1:0] bucket_of(input logic [KEY_BITS-1:0] k);
        logic [KEY_BITS+16:0] kk;
        kk = {{17{1'b0}}, k};
        return BW'(kk % BUCKETS);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLRH;
            len_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg  <= keep_next;
        func_reg  <= func_next;
        key_reg   <= key_next;
        link_reg  <= link_next;
        steps_reg <= steps_next;
        mo_reg    <= mo_next;
        found_reg <= found_next;
        st_reg    <= st_next;
    end

    always_comb
    begin
        logic [10:0] in_mark;
        in_mark    = s_axis_tdata[12:2];
        state_next = state_reg;
        len_next   = len_reg;
        keep_next  = keep_reg;
        func_next  = func_reg;
        key_next   = key_reg;
        link_next  = link_reg;
        clr_next   = clr_reg;
        steps_next = steps_reg;
        mo_next    = mo_reg;
        found_next = found_reg;
        st_next    = st_reg;
        hwe = 1'b0; hwa = clr_reg; hwd = '0; hra = bucket_of(key_reg);
        twe = 1'b0; twa = CW'(len_reg); twd = {key_reg, hrd};
        tra = CW'(len_reg - LW'(1));
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            S_CLRH:
            begin
                hwe = 1'b1;
                clr_next = clr_reg + BW'(1);
                if (32'(clr_reg) == BUCKETS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    func_next  = s_axis_tdata[1:0];
                    key_next   = s_axis_tdata[13 +: KEY_BITS];
                    found_next = 1'b0;
                    st_next    = ST_OK;
                    if (s_axis_tdata[1:0] == FUNC_CLEAR)
                    begin
                        keep_next = '0;
                    end
                    else if (s_axis_tdata[1:0] == FUNC_PUT ||
                             s_axis_tdata[1:0] == FUNC_CHECK)
                    begin
                        if (32'(in_mark) > 32'(len_reg))
                        begin
                            st_next = ST_RANGE;
                        end
                        keep_next = LW'(in_mark);
                    end
                    else
                    begin
                        keep_next = len_reg;
                    end
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (st_reg != ST_OK || func_reg == FUNC_NONE)
                begin
                    state_next = S_OUT;
                end
                else if (len_reg > keep_reg)
                begin
                    state_next = S_UNDO_RD;
                end
                else if (func_reg == FUNC_CHECK)
                begin
                    state_next = S_HEAD_RD;
                end
                else if (func_reg == FUNC_PUT)
                begin
                    if (32'(len_reg) >= CAPACITY)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_HEAD_RD;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_UNDO_RD:
            begin
                state_next = S_UNDO_WAIT;
            end
            S_UNDO_WAIT:
            begin
                state_next = S_UNDO_WR;
            end
            S_UNDO_WR:
            begin
                hwe = 1'b1;
                hwa = bucket_of(trd_key);
                hwd = trd_next;
                len_next   = len_reg - LW'(1);
                state_next = S_DECIDE;
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_WAIT;
            end
            S_HEAD_WAIT:
            begin
                if (func_reg == FUNC_PUT)
                begin
                    state_next = S_PUT_WR;
                end
                else
                begin
                    link_next  = hrd;
                    steps_next = '0;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                tra = CW'(link_reg - LW'(1));
                if (link_reg == '0 || 32'(link_reg) > CAPACITY ||
                    32'(steps_reg) >= CAPACITY)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WALK_WAIT;
                end
            end
            S_WALK_WAIT:
            begin
                // keep the chain entry on the read port for the compare
                tra = CW'(link_reg - LW'(1));
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP:
            begin
                if (trd_key == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    link_next  = trd_next;
                    steps_next = steps_reg + LW'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_PUT_WR:
            begin
                twe = 1'b1;
                hwe = 1'b1;
                hwa = bucket_of(key_reg);
                hwd = len_reg + LW'(1);
                len_next   = len_reg + LW'(1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                mo_next = 11'(len_reg);
                state_next = S_OUT;
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // S_OUT drives mark_out straight from len_reg, which is stable in that state
    logic [10:0] mo_live;
    assign mo_live = 11'(len_reg);
    assign m_axis_tdata = {2'b00, st_reg, found_reg, (state_reg == S_OUT) ? mo_live : mo_reg};
endmodule

FILE: design/bhs_ram.sv
`timescale 1ns / 1ps
module bhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
